### sv/configurable_byte_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// Byte deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONFIGURABLE_BYTE_DEFRAMER_TOP_MACROS_SVH
`define CONFIGURABLE_BYTE_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication.
`define CBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cbd_pkg.sv
// ----------------------------------------------------------------------------
// Byte deframer package
// Register map, status codes, configuration bundle and small helpers.
// ----------------------------------------------------------------------------
package cbd_pkg;

    // Limits
    localparam logic [12:0] MAX_FRAME     = 13'd4096;
    localparam logic [12:0] MIN_FRAME_LEN = 13'd0;
    localparam int          PATTERN_BYTES = 4;
    localparam logic [2:0]  PAT_CAP       = (PATTERN_BYTES < 4) ? 3'(PATTERN_BYTES) : 3'd4;

    // Register indexes
    localparam logic [2:0] REG_HEADER_PATTERN = 3'd0;
    localparam logic [2:0] REG_HEADER_LEN     = 3'd1;
    localparam logic [2:0] REG_TAIL_PATTERN   = 3'd2;
    localparam logic [2:0] REG_TAIL_LEN       = 3'd3;
    localparam logic [2:0] REG_LENGTH_MODE    = 3'd4;
    localparam logic [2:0] REG_LENGTH_OFFSET  = 3'd5;
    localparam logic [2:0] REG_LENGTH_ADJUST  = 3'd6;
    localparam logic [2:0] REG_LEN_LIMIT      = 3'd7;

    // Length modes; the spare code behaves as fixed length
    localparam logic [1:0] LEN_MODE_FIXED     = 2'd0;
    localparam logic [1:0] LEN_MODE_ONE       = 2'd1;
    localparam logic [1:0] LEN_MODE_TWO       = 2'd2;
    localparam logic [1:0] LEN_MODE_FIXED_ALT = 2'd3;

    // Frame status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_LONG  = 2'd2;

    localparam logic [12:0] LEN_LIMIT_RESET = 13'd4096;

    typedef struct packed {
        logic [31:0] header_pattern;
        logic [2:0]  header_len;
        logic [31:0] tail_pattern;
        logic [2:0]  tail_len;
        logic [1:0]  length_mode;
        logic [7:0]  length_offset;
        logic [15:0] length_adjust;
        logic [12:0] len_limit;
    } cbd_cfg_t;

    localparam cbd_cfg_t CFG_RESET = '{
        header_pattern: 32'h0,
        header_len:     3'd0,
        tail_pattern:   32'h0,
        tail_len:       3'd0,
        length_mode:    LEN_MODE_FIXED,
        length_offset:  8'd0,
        length_adjust:  16'd0,
        len_limit:      LEN_LIMIT_RESET
    };

    // Byte handed from the hunter to the frame stage
    typedef struct packed {
        logic       fire;
        logic [7:0] data;
    } cbd_emit_t;

    // Frame stage feedback to the hunter
    typedef struct packed {
        logic advance;
        logic closed;
    } cbd_frame_sts_t;

    function automatic logic [2:0] clamp_len(input logic [2:0] n);
        return (n > PAT_CAP) ? PAT_CAP : n;
    endfunction

    function automatic logic [31:0] byte_mask(input logic [2:0] n);
        logic [31:0] m;
        case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

### sv/configurable_byte_deframer_top.sv
// ----------------------------------------------------------------------------
// Configurable byte deframer
// Cuts a byte stream into frames by header, tail, fixed length, length field or limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/data_byte carries one stream byte per
//   transfer. Output channel out_valid/out_stall carries one frame byte per
//   transfer with its index, first and last marks and, on the last byte,
//   the frame status (ok, too short, too long).
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write
//   only while the block is idle. cfg_ready is always high.
//   A byte inside a frame passes the input register, then the result
//   register. Bytes dropped during the header hunt produce nothing.
//   Throughput: one byte per cycle unless the receiver stalls or a header
//   is replayed, set by the single result register. A completed header is
//   replayed through the same frame logic, with the input stalled.
//   Reset clears all frame and hunt state; registers return to zero, except
//   the frame length limit which returns to 4096. While the receiver stalls,
//   the result is held, one more input byte is buffered, then in_stall rises.
// ----------------------------------------------------------------------------
module configurable_byte_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic [11:0] byte_index,
    output logic        frame_first,
    output logic        frame_last,
    output logic [1:0]  frame_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import cbd_pkg::*;

    cbd_cfg_t       cfg_reg, cfg_next;
    cbd_emit_t      emit;
    cbd_frame_sts_t sts;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HEADER_PATTERN: cfg_next.header_pattern = cfg_data;
                REG_HEADER_LEN:     cfg_next.header_len     = cfg_data[2:0];
                REG_TAIL_PATTERN:   cfg_next.tail_pattern   = cfg_data;
                REG_TAIL_LEN:       cfg_next.tail_len       = cfg_data[2:0];
                REG_LENGTH_MODE:    cfg_next.length_mode    = cfg_data[1:0];
                REG_LENGTH_OFFSET:  cfg_next.length_offset  = cfg_data[7:0];
                REG_LENGTH_ADJUST:  cfg_next.length_adjust  = cfg_data[15:0];
                REG_LEN_LIMIT:      cfg_next.len_limit      = cfg_data[12:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    cbd_hunt u_hunt (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .sts       (sts),
        .emit      (emit)
    );

    cbd_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .emit         (emit),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .byte_index   (byte_index),
        .frame_first  (frame_first),
        .frame_last   (frame_last),
        .frame_status (frame_status)
    );

endmodule

### sv/cbd_hunt.sv
// ----------------------------------------------------------------------------
// Byte deframer header hunter
// Input register, header search window and replay of a matched header.
// ----------------------------------------------------------------------------
`include "configurable_byte_deframer_top_macros.svh"

module cbd_hunt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cbd_pkg::cbd_cfg_t       cfg,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              data_byte,
    input  cbd_pkg::cbd_frame_sts_t sts,
    output cbd_pkg::cbd_emit_t      emit
);
    import cbd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic [31:0] hunt_window_reg, hunt_window_next;
    logic [2:0]  hunt_fill_reg, hunt_fill_next;
    logic        in_frame_reg, in_frame_next;
    logic [31:0] burst_reg, burst_next;
    logic [2:0]  burst_cnt_reg, burst_cnt_next;

    logic        consume;
    logic        accept;
    logic        match_load;
    logic [2:0]  hl;
    logic [31:0] win_new;
    logic [2:0]  fill_new;

    assign hl       = clamp_len(cfg.header_len);
    assign win_new  = {hunt_window_reg[23:0], in_byte_reg};
    assign fill_new = (hunt_fill_reg < hl) ? hunt_fill_reg + 3'd1 : hunt_fill_reg;
    assign consume  = sts.advance && (burst_cnt_reg == 3'd0) && in_valid_reg;
    assign in_stall = in_valid_reg && !consume;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next    = in_valid_reg;
        in_byte_next     = in_byte_reg;
        hunt_window_next = hunt_window_reg;
        hunt_fill_next   = hunt_fill_reg;
        in_frame_next    = in_frame_reg;
        burst_next       = burst_reg;
        burst_cnt_next   = burst_cnt_reg;
        emit.fire        = 1'b0;
        emit.data        = in_byte_reg;
        match_load       = 1'b0;

        if (consume)
            in_valid_next = 1'b0;
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = data_byte;
        end

        if (sts.advance && burst_cnt_reg != 3'd0)
        begin
            // replay header bytes, oldest first
            emit.fire = 1'b1;
            emit.data = burst_reg[31:24];
            if (sts.closed)
            begin
                burst_cnt_next = 3'd0;
                in_frame_next  = 1'b0;
            end
            else
            begin
                burst_cnt_next = burst_cnt_reg - 3'd1;
                burst_next     = {burst_reg[23:0], 8'h00};
            end
        end
        else if (consume)
        begin
            if (in_frame_reg || hl == 3'd0)
            begin
                emit.fire        = 1'b1;
                hunt_window_next = 32'h0;
                hunt_fill_next   = 3'd0;
                in_frame_next    = !sts.closed;
            end
            else if (fill_new >= hl &&
                     ((win_new ^ cfg.header_pattern) & byte_mask(hl)) == 32'h0)
            begin
                match_load       = 1'b1;
                hunt_window_next = 32'h0;
                hunt_fill_next   = 3'd0;
                in_frame_next    = 1'b1;
                burst_cnt_next   = hl;
                // left-align the header so its first byte sits on top
                case (hl)
                    3'd1:    burst_next = {win_new[7:0], 24'h0};
                    3'd2:    burst_next = {win_new[15:0], 16'h0};
                    3'd3:    burst_next = {win_new[23:0], 8'h0};
                    default: burst_next = win_new;
                endcase
            end
            else
            begin
                hunt_window_next = win_new;
                hunt_fill_next   = fill_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            hunt_window_reg <= 32'h0;
            hunt_fill_reg   <= 3'd0;
            in_frame_reg    <= 1'b0;
            burst_cnt_reg   <= 3'd0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            hunt_window_reg <= hunt_window_next;
            hunt_fill_reg   <= hunt_fill_next;
            in_frame_reg    <= in_frame_next;
            burst_cnt_reg   <= burst_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        burst_reg   <= burst_next;
    end

    `CBD_ASSERT_NOW(a_burst_holds_input, burst_cnt_reg != 3'd0, !consume,
                    "input consumed during header replay")
    `CBD_ASSERT_NOW(a_burst_in_frame, burst_cnt_reg != 3'd0, in_frame_reg,
                    "header replay outside a frame")
    `CBD_ASSERT_NEXT(a_match_loads_burst, match_load, burst_cnt_reg != 3'd0,
                     "header match did not start a replay")

endmodule

### sv/cbd_frame.sv
// ----------------------------------------------------------------------------
// Byte deframer frame stage
// Per-byte frame bookkeeping, end-of-frame rules and the result register.
// ----------------------------------------------------------------------------
`include "configurable_byte_deframer_top_macros.svh"

module cbd_frame (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cbd_pkg::cbd_cfg_t       cfg,
    input  cbd_pkg::cbd_emit_t      emit,
    output cbd_pkg::cbd_frame_sts_t sts,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              frame_byte,
    output logic [11:0]             byte_index,
    output logic                    frame_first,
    output logic                    frame_last,
    output logic [1:0]              frame_status
);
    import cbd_pkg::*;

    logic [12:0] frame_count_reg, frame_count_next;
    logic [31:0] tail_window_reg, tail_window_next;
    logic [15:0] length_value_reg, length_value_next;
    logic        length_known_reg, length_known_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [11:0] out_index_reg;
    logic        out_first_reg, out_last_reg;
    logic [1:0]  out_status_reg;

    logic [12:0]        len;
    logic [12:0]        lim;
    logic [2:0]         hl, tl;
    logic [31:0]        tw_shift;
    logic [12:0]        lo13, lo_p1;
    logic [15:0]        lv;
    logic               known;
    logic signed [17:0] target, len_s, adj_s;
    logic               done, shortf, longf;
    logic [1:0]         status;

    assign len      = frame_count_reg + 13'd1;
    assign hl       = clamp_len(cfg.header_len);
    assign tl       = clamp_len(cfg.tail_len);
    assign lim      = (cfg.len_limit == 13'd0 || cfg.len_limit > MAX_FRAME)
                      ? MAX_FRAME : cfg.len_limit;
    assign tw_shift = {tail_window_reg[23:0], emit.data};
    assign lo13     = {5'b0, cfg.length_offset};
    assign lo_p1    = lo13 + 13'd1;
    assign len_s    = $signed({5'b0, len});
    assign adj_s    = $signed({{2{cfg.length_adjust[15]}}, cfg.length_adjust});

    always_comb
    begin
        tail_window_next  = tail_window_reg;
        lv                = length_value_reg;
        known             = length_known_reg;
        target            = adj_s;
        done              = 1'b0;
        shortf            = 1'b0;
        longf             = 1'b0;

        if (tl != 3'd0)
        begin
            // tail search covers bytes after the header only
            if (frame_count_reg >= {10'b0, hl})
            begin
                tail_window_next = tw_shift;
                if (len >= {10'b0, hl} + {10'b0, tl} &&
                    ((tw_shift ^ cfg.tail_pattern) & byte_mask(tl)) == 32'h0)
                    done = 1'b1;
            end
        end
        else
        begin
            case (cfg.length_mode)
                LEN_MODE_ONE:
                begin
                    if (frame_count_reg == lo13)
                    begin
                        lv    = {8'h00, emit.data};
                        known = 1'b1;
                    end
                    target = $signed({2'b00, lv}) + adj_s;
                end
                LEN_MODE_TWO:
                begin
                    if (frame_count_reg == lo13)
                        lv = {emit.data, 8'h00};
                    else if (frame_count_reg == lo_p1)
                    begin
                        lv    = length_value_reg | {8'h00, emit.data};
                        known = 1'b1;
                    end
                    target = $signed({2'b00, lv}) + adj_s;
                end
                default:
                begin
                    known  = 1'b1;
                    lv     = 16'h0;
                    target = adj_s;
                end
            endcase
            if (known && target <= len_s)
            begin
                done   = 1'b1;
                shortf = target < len_s;
            end
        end

        if (done)
        begin
            if (len < MIN_FRAME_LEN)
                shortf = 1'b1;
        end
        else if (len >= lim)
        begin
            done  = 1'b1;
            longf = 1'b1;
        end

        if (!done)
            status = STATUS_OK;
        else if (longf)
            status = STATUS_LONG;
        else if (shortf)
            status = STATUS_SHORT;
        else
            status = STATUS_OK;
    end

    assign sts.advance = !out_valid_reg || !out_stall;
    assign sts.closed  = emit.fire && done;

    always_comb
    begin
        frame_count_next  = frame_count_reg;
        length_value_next = length_value_reg;
        length_known_next = length_known_reg;
        if (emit.fire)
        begin
            if (done)
            begin
                frame_count_next  = 13'd0;
                length_value_next = 16'h0;
                length_known_next = 1'b0;
            end
            else
            begin
                frame_count_next  = len;
                length_value_next = lv;
                length_known_next = known;
            end
        end
        out_valid_next = sts.advance ? emit.fire : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg  <= 13'd0;
            tail_window_reg  <= 32'h0;
            length_value_reg <= 16'h0;
            length_known_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_count_reg  <= frame_count_next;
            length_value_reg <= length_value_next;
            length_known_reg <= length_known_next;
            out_valid_reg    <= out_valid_next;
            if (emit.fire)
                tail_window_reg <= done ? 32'h0 : tail_window_next;
        end
    end

    // load the result register when the slot frees up and a byte is emitted
    always_ff @(posedge clk)
    begin
        if (sts.advance && emit.fire)
        begin
            out_byte_reg   <= emit.data;
            out_index_reg  <= frame_count_reg[11:0];
            out_first_reg  <= frame_count_reg == 13'd0;
            out_last_reg   <= done;
            out_status_reg <= status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_byte   = out_byte_reg;
    assign byte_index   = out_index_reg;
    assign frame_first  = out_first_reg;
    assign frame_last   = out_last_reg;
    assign frame_status = out_status_reg;

    `CBD_ASSERT_NOW(a_first_at_zero, out_valid_reg && out_first_reg,
                    out_index_reg == 12'd0, "first byte with nonzero index")
    `CBD_ASSERT_NOW(a_status_on_last, out_valid_reg && !out_last_reg,
                    out_status_reg == STATUS_OK, "status set on a non-last byte")
    `CBD_ASSERT_NEXT(a_close_resets_count, sts.closed && sts.advance,
                     frame_count_reg == 13'd0, "frame count not cleared on close")

endmodule
